### rtl/bpa_pkg.sv
package bpa_pkg;

  localparam int unsigned CNT_W = 17;
  localparam int unsigned ADDR_BITS = 48;
  localparam int unsigned BIT_W = 6;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] ACT_INIT = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_OOM = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] reserved;
    logic [CNT_W-1:0] res_word;
    logic [CNT_W-1:0] last_word;
    logic [BIT_W-1:0] res_bit;
    logic [BIT_W-1:0] last_bit;
  } geo_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    status_t              status;
    logic [CNT_W-1:0]     count;
  } res_t;

endpackage

### rtl/bpa_ram.sv
module bpa_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DATA_W = 64,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/bpa_wdiv.sv
module bpa_wdiv import bpa_pkg::*; #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                         clk,
  input  logic [CNT_W-1:0]             value_i,
  output logic [CNT_W-1:0]             quot_o,
  output logic [$clog2(WORD_BITS)-1:0] rem_o
);

  localparam int unsigned BIT_IDX_W = $clog2(WORD_BITS);
  localparam int unsigned SH = CNT_W + BIT_IDX_W;
  localparam int unsigned PW = SH + CNT_W + 1;
  localparam longint unsigned RECIP = ((64'd1 << SH) + WORD_BITS - 1) / WORD_BITS;

  logic [PW-1:0]        prod;
  logic [CNT_W-1:0]     quot_r;
  logic [CNT_W-1:0]     val_r;
  logic [CNT_W-1:0]     back;
  logic [BIT_IDX_W-1:0] rem_r;

  // The quotient comes from a scaled reciprocal that is exact for every 17-bit value.
  assign prod = PW'(value_i) * PW'(RECIP);
  assign back = CNT_W'(quot_r * CNT_W'(WORD_BITS));

  always_ff @(posedge clk) begin
    quot_r <= CNT_W'(prod >> SH);
    val_r  <= value_i;
    rem_r  <= BIT_IDX_W'(val_r - back);
  end

  assign quot_o = quot_r;
  assign rem_o  = rem_r;

endmodule

### rtl/bpa_engine.sv
module bpa_engine import bpa_pkg::*; #(
  parameter int unsigned MAX_PAGES = 65536,
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned PAGE_SHIFT = 12,
  parameter int unsigned ADDR_W = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [ADDR_BITS-1:0] in_page_address,
  input  geo_t                 geo,
  output logic                 res_valid,
  output res_t                 res,
  input  logic                 res_take,
  output logic                 ram_we,
  output logic [ADDR_W-1:0]    ram_waddr,
  output logic [WORD_BITS-1:0] ram_wdata,
  output logic [ADDR_W-1:0]    ram_raddr,
  input  logic [WORD_BITS-1:0] ram_rdata
);

  localparam int unsigned NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned BIT_IDX_W = $clog2(WORD_BITS);
  localparam int unsigned PG_W = ADDR_W + BIT_IDX_W;
  localparam int unsigned PN_W = ADDR_BITS - PAGE_SHIFT;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_WORDS - 1);
  localparam logic [WORD_BITS-1:0] ONES = '1;
  localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_SETUP      = 8'b0000_0010,
    S_GO         = 8'b0000_0100,
    S_SWEEP      = 8'b0000_1000,
    S_SCAN       = 8'b0001_0000,
    S_ALLOC_ADDR = 8'b0010_0000,
    S_FREE_CHK   = 8'b0100_0000,
    S_DONE       = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           act_r, act_nxt;
  logic                 range_r, range_nxt;
  logic [ADDR_W-1:0]    sweep_r, sweep_nxt;
  logic                 sweep_init_r, sweep_init_nxt;
  logic [ADDR_W-1:0]    rd_addr_r, rd_addr_nxt;
  logic [ADDR_W-1:0]    chk_addr_r, chk_addr_nxt;
  logic                 chk_valid_r, chk_valid_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;
  logic [BIT_IDX_W-1:0] hit_bit_r, hit_bit_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ADDR_BITS-1:0] res_addr_r, res_addr_nxt;
  status_t              res_status_r, res_status_nxt;

  logic [CNT_W-1:0]     fdiv_quot;
  logic [BIT_IDX_W-1:0] fdiv_rem;
  logic [PN_W-1:0]      page_num;
  logic                 in_range_bad;
  logic [CNT_W-1:0]     chk_ext;
  logic [CNT_W-1:0]     sweep_ext;
  logic [BIT_IDX_W-1:0] res_bit;
  logic [BIT_IDX_W-1:0] last_bit;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] cand;
  logic                 hit;
  logic [BIT_IDX_W-1:0] hit_idx;
  logic [WORD_BITS-1:0] sweep_word;
  logic [PG_W-1:0]      alloc_page;

  bpa_wdiv #(.WORD_BITS(WORD_BITS)) u_fdiv (
    .clk     (clk),
    .value_i (in_page_address[PAGE_SHIFT +: CNT_W]),
    .quot_o  (fdiv_quot),
    .rem_o   (fdiv_rem)
  );

  assign page_num     = in_page_address[ADDR_BITS-1:PAGE_SHIFT];
  assign in_range_bad = page_num >= PN_W'(geo.total);
  assign chk_ext      = CNT_W'(chk_addr_r);
  assign sweep_ext    = CNT_W'(sweep_r);
  assign res_bit      = geo.res_bit[BIT_IDX_W-1:0];
  assign last_bit     = geo.last_bit[BIT_IDX_W-1:0];
  assign lo_mask      = (chk_ext == geo.res_word) ? (ONES << res_bit) : ONES;
  assign hi_mask      = (chk_ext == geo.last_word) ?
                        (ONES >> (BIT_IDX_W'(WORD_BITS - 1) - last_bit)) : ONES;
  assign cand         = ~ram_rdata & lo_mask & hi_mask;
  assign hit          = |cand;
  assign alloc_page   = PG_W'(PG_W'(chk_addr_r) * PG_W'(WORD_BITS)) + PG_W'(hit_bit_r);

  always_comb begin
    hit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_idx = BIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (!sweep_init_r) begin
      sweep_word = '0;
    end else if (sweep_ext < geo.res_word) begin
      sweep_word = ONES;
    end else if (sweep_ext == geo.res_word) begin
      sweep_word = ~(ONES << res_bit);
    end else begin
      sweep_word = '0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    range_nxt      = range_r;
    sweep_nxt      = sweep_r;
    sweep_init_nxt = sweep_init_r;
    rd_addr_nxt    = rd_addr_r;
    chk_addr_nxt   = chk_addr_r;
    chk_valid_nxt  = chk_valid_r;
    bit_nxt        = bit_r;
    hit_bit_nxt    = hit_bit_r;
    count_nxt      = count_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_nxt   = in_action;
          range_nxt = in_range_bad;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        rd_addr_nxt = ADDR_W'(fdiv_quot);
        state_nxt   = S_GO;
      end
      S_GO: begin
        res_addr_nxt   = '0;
        res_status_nxt = ST_OK;
        case (act_r)
          ACT_INIT: begin
            count_nxt      = geo.total - geo.reserved;
            sweep_nxt      = '0;
            sweep_init_nxt = 1'b1;
            state_nxt      = S_SWEEP;
          end
          ACT_ALLOC: begin
            if (count_r == '0 || geo.reserved >= geo.total) begin
              res_status_nxt = ST_OOM;
              state_nxt      = S_DONE;
            end else begin
              rd_addr_nxt   = ADDR_W'(geo.res_word);
              chk_valid_nxt = 1'b0;
              state_nxt     = S_SCAN;
            end
          end
          ACT_FREE: begin
            if (range_r) begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_DONE;
            end else begin
              bit_nxt   = fdiv_rem;
              state_nxt = S_FREE_CHK;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = sweep_word;
        if (sweep_r == LAST_IDX) begin
          state_nxt = sweep_init_r ? S_DONE : S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      S_SCAN: begin
        if (chk_valid_r && hit) begin
          ram_we      = 1'b1;
          ram_waddr   = chk_addr_r;
          ram_wdata   = ram_rdata | (ONE << hit_idx);
          hit_bit_nxt = hit_idx;
          count_nxt   = count_r - 1'b1;
          state_nxt   = S_ALLOC_ADDR;
        end else if (chk_valid_r && chk_ext == geo.last_word) begin
          res_status_nxt = ST_OOM;
          state_nxt      = S_DONE;
        end else begin
          chk_valid_nxt = 1'b1;
          chk_addr_nxt  = rd_addr_r;
          if (CNT_W'(rd_addr_r) != geo.last_word) begin
            rd_addr_nxt = rd_addr_r + 1'b1;
          end
        end
      end
      S_ALLOC_ADDR: begin
        res_addr_nxt = ADDR_BITS'(alloc_page) << PAGE_SHIFT;
        state_nxt    = S_DONE;
      end
      S_FREE_CHK: begin
        if (!ram_rdata[bit_r]) begin
          res_status_nxt = ST_ALREADY_FREE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = rd_addr_r;
          ram_wdata = ram_rdata & ~(ONE << bit_r);
          if (count_r != COUNT_MAX) begin
            count_nxt = count_r + 1'b1;
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      sweep_r      <= '0;
      sweep_init_r <= 1'b0;
      chk_valid_r  <= 1'b0;
      count_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      sweep_r      <= sweep_nxt;
      sweep_init_r <= sweep_init_nxt;
      chk_valid_r  <= chk_valid_nxt;
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    range_r      <= range_nxt;
    rd_addr_r    <= rd_addr_nxt;
    chk_addr_r   <= chk_addr_nxt;
    bit_r        <= bit_nxt;
    hit_bit_r    <= hit_bit_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
  end

  assign ram_raddr  = rd_addr_r;
  assign res.addr   = res_addr_r;
  assign res.status = res_status_r;
  assign res.count  = count_r;

endmodule

### rtl/bitmap_page_allocator_top.sv
// Bitmap page allocator with one used bit per page, held in a word-wide RAM.
// Input words carry an action and a page address; every accepted word yields
// exactly one result word with the allocated address, a status and the free
// page count left. Both channels use valid/ready handshakes.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata;
// the user writes them only while no request is in flight, which the block
// itself does not enforce; they act on the next request.
// Each request passes the setup and go states. A no-op, an out-of-range free
// and an allocate rejected at once then give their result; any other free
// first checks and clears its page bit. An allocate walks the bitmap words
// from the reserved limit upward through the single RAM read port, then forms
// the page address, or reports out of memory at the last word.
// Init rewrites every bitmap word, one word per cycle.
// One request is in flight at a time; the next one is accepted the cycle
// after the result moves to the output register.
// After reset the block clears the bitmap RAM with in_ready low; configuration
// writes are still taken. The free count is zero until the first init.
// A finished result sits in the output register; the next request is accepted
// meanwhile and waits at its end only if that register is still occupied.
module bitmap_page_allocator_top import bpa_pkg::*; #(
  parameter int unsigned MAX_PAGES = 65536,
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [ADDR_BITS-1:0] in_page_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_BITS-1:0] out_allocated_address,
  output logic [1:0]           out_status,
  output logic [CNT_W-1:0]     out_free_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_wdata
);

  localparam int unsigned NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned BIT_IDX_W = $clog2(WORD_BITS);

  logic [CNT_W-1:0]     total_r, total_nxt;
  logic [CNT_W-1:0]     reserved_r, reserved_nxt;
  logic [CNT_W-1:0]     eff_total;
  logic [CNT_W-1:0]     eff_res;
  logic [CNT_W-1:0]     last_page;
  logic [CNT_W-1:0]     res_word;
  logic [CNT_W-1:0]     last_word;
  logic [BIT_IDX_W-1:0] res_bit;
  logic [BIT_IDX_W-1:0] last_bit;
  geo_t                 geo;

  logic                 res_valid;
  res_t                 res;
  logic                 res_take;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_r;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  always_comb begin
    total_nxt    = total_r;
    reserved_nxt = reserved_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL:    total_nxt = cfg_wdata;
        CFG_RESERVED: reserved_nxt = cfg_wdata;
        default:      total_nxt = total_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= CNT_W'(65536);
      reserved_r <= '0;
    end else begin
      total_r    <= total_nxt;
      reserved_r <= reserved_nxt;
    end
  end

  assign eff_total = (32'(total_r) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : total_r;
  assign eff_res   = (reserved_r > eff_total) ? eff_total : reserved_r;
  assign last_page = (eff_total == '0) ? '0 : eff_total - 1'b1;

  bpa_wdiv #(.WORD_BITS(WORD_BITS)) u_res_div (
    .clk     (clk),
    .value_i (eff_res),
    .quot_o  (res_word),
    .rem_o   (res_bit)
  );

  bpa_wdiv #(.WORD_BITS(WORD_BITS)) u_last_div (
    .clk     (clk),
    .value_i (last_page),
    .quot_o  (last_word),
    .rem_o   (last_bit)
  );

  assign geo.total     = eff_total;
  assign geo.reserved  = eff_res;
  assign geo.res_word  = res_word;
  assign geo.last_word = last_word;
  assign geo.res_bit   = BIT_W'(res_bit);
  assign geo.last_bit  = BIT_W'(last_bit);

  bpa_ram #(
    .DEPTH  (NUM_WORDS),
    .DATA_W (WORD_BITS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpa_engine #(
    .MAX_PAGES  (MAX_PAGES),
    .WORD_BITS  (WORD_BITS),
    .PAGE_SHIFT (PAGE_SHIFT),
    .ADDR_W     (ADDR_W)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_page_address (in_page_address),
    .geo             (geo),
    .res_valid       (res_valid),
    .res             (res),
    .res_take        (res_take),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  assign res_take = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_allocated_address = out_r.addr;
  assign out_status            = out_r.status;
  assign out_free_count        = out_r.count;

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_allocated_address == '0)
    else $error("failed request carries a page address");

  a_ram_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !in_ready)
    else $error("bitmap written while idle");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("request accepted before bitmap clear");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while one is in flight");

endmodule
